[sv/scroll_velocity_ema_prefetch_core_macros.svh]
// Assertion macros for the scroll velocity estimator.
// Depends on a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef SCROLL_VELOCITY_EMA_PREFETCH_CORE_MACROS_SVH
`define SCROLL_VELOCITY_EMA_PREFETCH_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk, off during reset.
`define SVEP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svep assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SVEP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("svep assertion failed");

`else

`define SVEP_ASSERT_IMPL(lbl, ante, cons)
`define SVEP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[sv/svep_pkg.sv]
// Package for the scroll velocity estimator: field widths, command and register codes,
// arithmetic constants and the divider status type. No dependencies.
package svep_pkg;

  localparam int CMD_W      = 2;
  localparam int DELTA_W    = 16;
  localparam int TS_FIELD_W = 48;
  localparam int TOP_W      = 24;
  localparam int VEL_W      = 32;
  localparam int PRED_W     = 29;
  localparam int START_W    = 25;
  localparam int COUNT_W    = 21;
  localparam int DIR_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Dividend of the speed division: |delta| * 1e6 * 256 stays below 2**43.
  localparam int NUM_W = 43;

  localparam logic [CMD_W-1:0] CMD_ADD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EVALUATE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESET_HIST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FAST_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_ENABLE = 2'd1;

  localparam logic [VEL_W-1:0] FAST_THRESHOLD_RST = 32'd12800;
  localparam logic [VEL_W-1:0] MIN_THRESHOLD      = 32'd256;

  localparam logic [19:0] US_PER_S   = 20'd1000000;
  localparam logic [15:0] ALPHA_Q15  = 16'd9830;
  localparam logic [15:0] ROUND_HALF = 16'd16384;
  localparam int          Q15_SHIFT  = 15;
  // ceil(2**35 / 10): exact divide by ten for any 32-bit value.
  localparam logic [31:0] RECIP_10   = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;
  localparam logic [COUNT_W-1:0] LOOKAHEAD_EXTRA = 21'd4;

  localparam logic signed [DIR_W-1:0] DIR_NONE = 2'sb00;
  localparam logic signed [DIR_W-1:0] DIR_FWD  = 2'sb01;
  localparam logic signed [DIR_W-1:0] DIR_BACK = 2'sb11;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[sv/svep_if.sv]
// Channel interfaces of the scroll velocity estimator: input items, results, config writes.
// Depends on svep_pkg.
interface svep_in_if;
  import svep_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic signed [DELTA_W-1:0] delta_items;
  logic [TS_FIELD_W-1:0]   timestamp_us;
  logic [TOP_W-1:0]        top_index;

  modport source (output valid, command, delta_items, timestamp_us, top_index,
                  input ready);
  modport sink   (input valid, command, delta_items, timestamp_us, top_index,
                  output ready);
endinterface

interface svep_out_if;
  import svep_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [VEL_W-1:0]        items_per_second;
  logic [PRED_W-1:0]       predicted_items;
  logic                    fast_scroll;
  logic signed [DIR_W-1:0] scroll_direction;
  logic                    trigger_valid;
  logic [START_W-1:0]      trigger_start;
  logic [COUNT_W-1:0]      trigger_count;
  logic signed [DIR_W-1:0] trigger_direction;

  modport source (output valid, items_per_second, predicted_items, fast_scroll,
                  scroll_direction, trigger_valid, trigger_start, trigger_count,
                  trigger_direction, input ready);
  modport sink   (input valid, items_per_second, predicted_items, fast_scroll,
                  scroll_direction, trigger_valid, trigger_start, trigger_count,
                  trigger_direction, output ready);
endinterface

interface svep_cfg_if;
  import svep_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/svep_div.sv]
// Restoring radix-2 divider, one quotient bit per cycle, used by the speed update.
// Depends on svep_pkg.
module svep_div #(
  parameter int DIVISOR_W = 48
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [svep_pkg::NUM_W-1:0]  dividend,
  input  logic [DIVISOR_W-1:0]        divisor,
  output logic [svep_pkg::NUM_W-1:0]  quotient,
  output svep_pkg::div_status_t       status
);
  import svep_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam logic [CNT_W-1:0] STEPS = CNT_W'(NUM_W);
  localparam logic [CNT_W-1:0] ONE   = CNT_W'(1);

  logic [NUM_W-1:0]     quo_r, quo_nxt;
  logic [DIVISOR_W-1:0] rem_r, rem_nxt;
  logic [DIVISOR_W-1:0] dsr_r, dsr_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  logic [DIVISOR_W:0]   rem_sh;
  logic [DIVISOR_W:0]   rem_diff;
  logic                 fits;

  // Shift in the next dividend bit and try the subtract.
  assign rem_sh   = {rem_r, quo_r[NUM_W-1]};
  assign fits     = rem_sh >= {1'b0, dsr_r};
  assign rem_diff = rem_sh - {1'b0, dsr_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = STEPS;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], fits};
      cnt_nxt = cnt_r - ONE;
      if (cnt_r == ONE) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient    = quo_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

[sv/scroll_velocity_ema_prefetch_core.sv]
// Top level of the scroll velocity estimator with prefetch trigger.
// Depends on svep_pkg, svep_if.sv, svep_div and scroll_velocity_ema_prefetch_core_macros.svh.
`include "scroll_velocity_ema_prefetch_core_macros.svh"

// Scroll velocity estimator. Each transfer on in_ch carries one command (add sample,
// evaluate prefetch, reset history) and produces exactly one result transfer on out_ch.
// An add sample that has a previous sample and a later timestamp computes the speed
// |delta| * 1e6 * 256 / dt (Q24.8, saturating at all ones) on a restoring divider that
// retires one quotient bit per cycle over 43 steps, then folds it into the EMA
// (alpha 9830/32768, rounded half up). Such a sample runs through prepare, load, divide,
// EMA, predict and finish before in_ch.ready rises again; other commands skip load, divide
// and EMA. The 100 ms prediction is a registered reciprocal multiply by one tenth.
// A result register decouples out_ch: the next command is accepted while the previous
// result still waits, and the block stalls only when a new result is ready before the
// old one has been taken. cfg_ch is always ready; write it while no command is in flight.
module scroll_velocity_ema_prefetch_core #(
  parameter int TIMESTAMP_BITS = 48
) (
  input  logic       clk,
  input  logic       rst_n,
  svep_in_if.sink    in_ch,
  svep_out_if.source out_ch,
  svep_cfg_if.sink   cfg_ch
);
  import svep_pkg::*;

  localparam int TSW = TIMESTAMP_BITS;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_PREP = 7'b0000010,
    ST_LOAD = 7'b0000100,
    ST_DIV  = 7'b0001000,
    ST_EMA  = 7'b0010000,
    ST_PRED = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Captured command.
  logic [CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [DELTA_W-1:0] delta_r, delta_nxt;
  logic [TSW-1:0]     ts_r, ts_nxt;
  logic [TOP_W-1:0]   top_r, top_nxt;

  // History and smoothed speed.
  logic [TSW-1:0]     prev_ts_r, prev_ts_nxt;
  logic [DELTA_W-1:0] last_delta_r, last_delta_nxt;
  logic [1:0]         samples_r, samples_nxt;
  logic [VEL_W-1:0]   smooth_r, smooth_nxt;

  // Configuration.
  logic [VEL_W-1:0]   thr_r, thr_nxt;
  logic               trig_en_r, trig_en_nxt;

  // Datapath registers.
  logic [NUM_W-1:0]   num_r, num_nxt;
  logic [TSW-1:0]     dt_r, dt_nxt;
  logic [PRED_W-1:0]  pred_r, pred_nxt;

  // Result register.
  logic                    out_valid_r, out_valid_nxt;
  logic [VEL_W-1:0]        o_ips_r, o_ips_nxt;
  logic [PRED_W-1:0]       o_pred_r, o_pred_nxt;
  logic                    o_fast_r, o_fast_nxt;
  logic signed [DIR_W-1:0] o_dir_r, o_dir_nxt;
  logic                    o_tv_r, o_tv_nxt;
  logic [START_W-1:0]      o_ts_r, o_ts_nxt;
  logic [COUNT_W-1:0]      o_tc_r, o_tc_nxt;
  logic signed [DIR_W-1:0] o_td_r, o_td_nxt;

  // Divider.
  logic              div_start;
  logic [NUM_W-1:0]  div_quo;
  div_status_t       div_stat;

  svep_div #(
    .DIVISOR_W(TSW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num_r),
    .divisor  (dt_r),
    .quotient (div_quo),
    .status   (div_stat)
  );

  // Timestamp field resized to the timestamp width in use.
  logic [TSW+TS_FIELD_W-1:0] ts_ext;
  logic [TSW-1:0]            ts_in;
  assign ts_ext = {{TSW{1'b0}}, in_ch.timestamp_us};
  assign ts_in  = ts_ext[TSW-1:0];

  // Sample preparation terms.
  logic [1:0]          samples_inc;
  logic                do_update;
  logic [DELTA_W-1:0]  mag;
  logic [35:0]         mag_prod;
  assign samples_inc = (samples_r == 2'd2) ? 2'd2 : samples_r + 2'd1;
  assign do_update   = (samples_inc == 2'd2) && (ts_r > prev_ts_r);
  assign mag         = delta_r[DELTA_W-1] ? (16'd0 - delta_r) : delta_r;
  assign mag_prod    = {20'd0, mag} * {16'd0, US_PER_S};

  // EMA: v + ((9830 * (inst - v) + 16384) >>> 15), equal to the weighted form.
  logic [VEL_W-1:0]  inst;
  logic signed [32:0] ema_diff;
  logic signed [48:0] ema_x;
  logic signed [48:0] ema_term;
  assign inst     = (|div_quo[NUM_W-1:VEL_W]) ? '1 : div_quo[VEL_W-1:0];
  assign ema_diff = $signed({1'b0, inst}) - $signed({1'b0, smooth_r});
  assign ema_x    = $signed(49'(ema_diff)) * $signed({33'd0, ALPHA_Q15})
                  + $signed({33'd0, ROUND_HALF});
  assign ema_term = ema_x >>> Q15_SHIFT;

  // Prediction: divide by ten through the reciprocal.
  logic [63:0] pred_prod;
  assign pred_prod = {32'd0, smooth_r} * {32'd0, RECIP_10};

  // Result terms.
  logic [VEL_W-1:0]        eff_thr;
  logic signed [DIR_W-1:0] dir_now;
  logic                    trig;
  logic [COUNT_W-1:0]      count;
  logic [START_W-1:0]      start_fwd;
  logic [START_W-1:0]      start_back;
  assign eff_thr    = (thr_r < MIN_THRESHOLD) ? MIN_THRESHOLD : thr_r;
  assign dir_now    = (samples_r == 2'd0 || last_delta_r == '0) ? DIR_NONE :
                      (last_delta_r[DELTA_W-1] ? DIR_BACK : DIR_FWD);
  assign trig       = (cmd_r == CMD_EVALUATE) && trig_en_r && (smooth_r >= eff_thr);
  assign count      = pred_r[PRED_W-1:8] + LOOKAHEAD_EXTRA;
  assign start_fwd  = {1'b0, top_r} + 25'd1;
  assign start_back = (top_r > {3'd0, count}) ? {1'b0, top_r - {3'd0, count}} : '0;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    delta_nxt      = delta_r;
    ts_nxt         = ts_r;
    top_nxt        = top_r;
    prev_ts_nxt    = prev_ts_r;
    last_delta_nxt = last_delta_r;
    samples_nxt    = samples_r;
    smooth_nxt     = smooth_r;
    thr_nxt        = thr_r;
    trig_en_nxt    = trig_en_r;
    num_nxt        = num_r;
    dt_nxt         = dt_r;
    pred_nxt       = pred_r;
    div_start      = 1'b0;
    // Drop the result once it transfers.
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    o_ips_nxt      = o_ips_r;
    o_pred_nxt     = o_pred_r;
    o_fast_nxt     = o_fast_r;
    o_dir_nxt      = o_dir_r;
    o_tv_nxt       = o_tv_r;
    o_ts_nxt       = o_ts_r;
    o_tc_nxt       = o_tc_r;
    o_td_nxt       = o_td_r;

    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_FAST_THRESHOLD: thr_nxt     = cfg_ch.data;
        REG_TRIGGER_ENABLE: trig_en_nxt = cfg_ch.data[0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt   = in_ch.command;
          delta_nxt = in_ch.delta_items;
          ts_nxt    = ts_in;
          top_nxt   = in_ch.top_index;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        // Apply the command to the history; launch the division only when it counts.
        num_nxt   = {mag_prod[NUM_W-9:0], 8'd0};
        dt_nxt    = ts_r - prev_ts_r;
        state_nxt = ST_PRED;
        case (cmd_r)
          CMD_ADD_SAMPLE: begin
            samples_nxt    = samples_inc;
            prev_ts_nxt    = ts_r;
            last_delta_nxt = delta_r;
            if (do_update) state_nxt = ST_LOAD;
          end
          CMD_RESET_HIST: begin
            samples_nxt    = 2'd0;
            prev_ts_nxt    = '0;
            last_delta_nxt = '0;
            smooth_nxt     = '0;
          end
          default: ;
        endcase
      end
      ST_LOAD: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) state_nxt = ST_EMA;
      end
      ST_EMA: begin
        smooth_nxt = smooth_r + ema_term[VEL_W-1:0];
        state_nxt  = ST_PRED;
      end
      ST_PRED: begin
        pred_nxt  = pred_prod[63:RECIP_SHIFT];
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // Hold until the result register is free.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          o_ips_nxt     = smooth_r;
          o_pred_nxt    = pred_r;
          o_fast_nxt    = smooth_r > eff_thr;
          o_dir_nxt     = dir_now;
          o_tv_nxt      = trig;
          o_tc_nxt      = trig ? count : '0;
          o_ts_nxt      = '0;
          o_td_nxt      = DIR_NONE;
          if (trig) begin
            o_ts_nxt = (dir_now == DIR_BACK) ? start_back : start_fwd;
            o_td_nxt = (dir_now == DIR_BACK) ? DIR_BACK : DIR_FWD;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    delta_r  <= delta_nxt;
    ts_r     <= ts_nxt;
    top_r    <= top_nxt;
    num_r    <= num_nxt;
    dt_r     <= dt_nxt;
    pred_r   <= pred_nxt;
    o_ips_r  <= o_ips_nxt;
    o_pred_r <= o_pred_nxt;
    o_fast_r <= o_fast_nxt;
    o_dir_r  <= o_dir_nxt;
    o_tv_r   <= o_tv_nxt;
    o_ts_r   <= o_ts_nxt;
    o_tc_r   <= o_tc_nxt;
    o_td_r   <= o_td_nxt;
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      prev_ts_r    <= '0;
      last_delta_r <= '0;
      samples_r    <= 2'd0;
      smooth_r     <= '0;
      thr_r        <= FAST_THRESHOLD_RST;
      trig_en_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      prev_ts_r    <= prev_ts_nxt;
      last_delta_r <= last_delta_nxt;
      samples_r    <= samples_nxt;
      smooth_r     <= smooth_nxt;
      thr_r        <= thr_nxt;
      trig_en_r    <= trig_en_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid             = out_valid_r;
  assign out_ch.items_per_second  = o_ips_r;
  assign out_ch.predicted_items   = o_pred_r;
  assign out_ch.fast_scroll       = o_fast_r;
  assign out_ch.scroll_direction  = o_dir_r;
  assign out_ch.trigger_valid     = o_tv_r;
  assign out_ch.trigger_start     = o_ts_r;
  assign out_ch.trigger_count     = o_tc_r;
  assign out_ch.trigger_direction = o_td_r;

  // The divider only finishes while the sequencer waits for it.
  `SVEP_ASSERT_IMPL(a_div_done_in_div, div_stat.done, state_r == ST_DIV)
  // A trigger always asks for at least the look-ahead margin.
  `SVEP_ASSERT_IMPL(a_trig_count_min, out_valid_r && o_tv_r, o_tc_r >= LOOKAHEAD_EXTRA)
  // A trigger implies the reported speed reached the threshold.
  `SVEP_ASSERT_IMPL(a_trig_speed, out_valid_r && o_tv_r, o_ips_r >= eff_thr)
  // Leaving the divider wait always goes through the EMA update.
  `SVEP_ASSERT_NEXT(a_div_to_ema, state_r == ST_DIV && div_stat.done, state_r == ST_EMA)

endmodule

[verif/tb.sv]
// Self-checking testbench for scroll_velocity_ema_prefetch_core: directed and random
// command streams with a cycle-accurate-free speed/EMA/prefetch predictor.
// Depends on svep_pkg, svep_if.sv and the core RTL.
`timescale 1ns / 1ps

module tb;
  import svep_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 60;
  localparam int IDLE_PCT     = 16;
  localparam int RAND_PHASES  = 7;
  localparam int PHASE_ITEMS  = 250;

  // One result transfer as the block should present it.
  typedef struct {
    logic [VEL_W-1:0]   ips;
    logic [PRED_W-1:0]  pred;
    logic               fast;
    logic [DIR_W-1:0]   dir;
    logic               trig;
    logic [START_W-1:0] start;
    logic [COUNT_W-1:0] count;
    logic [DIR_W-1:0]   tdir;
  } speed_report_t;

  logic clk;
  logic rst_n;

  svep_in_if  in_ch();
  svep_out_if out_ch();
  svep_cfg_if cfg_ch();

  scroll_velocity_ema_prefetch_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow registers and estimator state of the predictor.
  logic [31:0] thr_reg;
  logic        trig_en_reg;
  logic [47:0] last_stamp;
  logic [15:0] last_step;
  int unsigned sample_count;
  logic [31:0] ema_speed;

  speed_report_t speed_reports_q[$];

  int unsigned mismatches;
  int unsigned cycles;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_triggers;
  int unsigned n_thresholds;
  int unsigned hold_asked;
  bit          calm;
  logic [47:0] clock_us;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles,
               speed_reports_q.size());
      $display("scroll_velocity_ema_prefetch_core regression: fail");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    if (mismatches < 30)
      $display("[%0t] MISMATCH %s: expected 0x%0h got 0x%0h", $time, what, want, got);
    mismatches++;
  endtask

  // Apply one command to the estimator state and return the result it should produce.
  function automatic speed_report_t advance_estimator(logic [1:0] cmd, logic [15:0] delta,
                                                      logic [47:0] ts, logic [23:0] top);
    speed_report_t r;
    logic [63:0] dt, mag, rate, acc, thr, tenth, cnt;
    logic [1:0]  dir;
    r = '{default: '0};
    if (cmd == CMD_ADD_SAMPLE) begin
      if (sample_count < 2) sample_count++;
      // Speed only from a second sample with a strictly later timestamp.
      if (sample_count >= 2 && ts > last_stamp) begin
        dt   = 64'(ts - last_stamp);
        mag  = delta[15] ? 64'(17'h10000 - {1'b0, delta}) : 64'(delta);
        rate = (mag * 64'd256_000_000) / dt;
        if (rate > 64'hFFFF_FFFF) rate = 64'hFFFF_FFFF;
        acc  = 64'd9830 * rate + 64'd22938 * 64'(ema_speed) + 64'd16384;
        ema_speed = acc[46:15];
      end
      last_stamp = ts;
      last_step  = delta;
    end else if (cmd == CMD_RESET_HIST) begin
      last_stamp   = '0;
      last_step    = '0;
      sample_count = 0;
      ema_speed    = '0;
    end

    thr   = (thr_reg < 32'd256) ? 64'd256 : 64'(thr_reg);
    tenth = 64'(ema_speed) / 64'd10;
    if (sample_count == 0 || last_step == 16'd0) dir = DIR_NONE;
    else if (last_step[15])                      dir = DIR_BACK;
    else                                         dir = DIR_FWD;

    r.ips  = ema_speed;
    r.pred = tenth[PRED_W-1:0];
    r.fast = (64'(ema_speed) > thr);
    r.dir  = dir;
    if (cmd == CMD_EVALUATE && trig_en_reg && 64'(ema_speed) >= thr) begin
      cnt     = (tenth >> 8) + 64'd4;
      r.trig  = 1'b1;
      r.count = cnt[COUNT_W-1:0];
      if (dir != DIR_BACK) begin
        r.start = 25'(top) + 25'd1;
        r.tdir  = DIR_FWD;
      end else begin
        r.start = (64'(top) > cnt) ? START_W'(64'(top) - cnt) : '0;
        r.tdir  = DIR_BACK;
      end
    end
    return r;
  endfunction

  // Offer one command after an optional random gap; return at the edge of its transfer
  // with valid still high so a following command can go out back to back.
  task automatic send_cmd(logic [1:0] cmd, logic [15:0] delta, logic [47:0] ts,
                          logic [23:0] top);
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= cmd;
    in_ch.delta_items  <= delta;
    in_ch.timestamp_us <= ts;
    in_ch.top_index    <= top;
    do @(posedge clk); while (!in_ch.ready);
    speed_reports_q.push_back(advance_estimator(cmd, delta, ts, top));
    n_sent++;
  endtask

  // Drop valid and wait until every expected result has been taken.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (speed_reports_q.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_FAST_THRESHOLD) begin
      thr_reg = val;
      n_thresholds++;
    end else begin
      trig_en_reg = val[0];
    end
  endtask

  // Drive out_ch.ready: random stalls, calm stretches and the long hold-off.
  initial begin
    int unsigned hold_left;
    int unsigned hold_given;
    hold_left  = 0;
    hold_given = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_asked != hold_given) begin
        hold_given = hold_asked;
        hold_left  = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    speed_report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (speed_reports_q.size() == 0) begin
        report_mismatch("unexpected result", 0, out_ch.items_per_second);
      end else begin
        want = speed_reports_q.pop_front();
        n_checked++;
        if (out_ch.trigger_valid === 1'b1) n_triggers++;
        if (out_ch.items_per_second !== want.ips)
          report_mismatch("items_per_second", want.ips, out_ch.items_per_second);
        if (out_ch.predicted_items !== want.pred)
          report_mismatch("predicted_items", want.pred, out_ch.predicted_items);
        if (out_ch.fast_scroll !== want.fast)
          report_mismatch("fast_scroll", want.fast, out_ch.fast_scroll);
        if (out_ch.scroll_direction !== want.dir)
          report_mismatch("scroll_direction", want.dir, out_ch.scroll_direction);
        if (out_ch.trigger_valid !== want.trig)
          report_mismatch("trigger_valid", want.trig, out_ch.trigger_valid);
        if (out_ch.trigger_start !== want.start)
          report_mismatch("trigger_start", want.start, out_ch.trigger_start);
        if (out_ch.trigger_count !== want.count)
          report_mismatch("trigger_count", want.count, out_ch.trigger_count);
        if (out_ch.trigger_direction !== want.tdir)
          report_mismatch("trigger_direction", want.tdir, out_ch.trigger_direction);
      end
    end
  end

  // First sample, saturated speed, equal and backward timestamps, unused command,
  // evaluate with triggers off; all under reset register values.
  task automatic test_history_edges();
    send_cmd(CMD_EVALUATE, 16'h0000, 48'd0, 24'd0);
    send_cmd(CMD_UNUSED, 16'h7FFF, 48'hFFFF_FFFF_FFFF, 24'hFF_FFFF);
    send_cmd(CMD_ADD_SAMPLE, 16'h7FFF, 48'd1000, 24'd0);
    send_cmd(CMD_ADD_SAMPLE, 16'h8000, 48'd1001, 24'd0);
    send_cmd(CMD_ADD_SAMPLE, 16'h0000, 48'd1001, 24'd0);
    send_cmd(CMD_ADD_SAMPLE, 16'h0005, 48'd500, 24'd0);
    send_cmd(CMD_EVALUATE, 16'h0000, 48'd0, 24'hFF_FFFF);
  endtask

  // Forward trigger starting past the largest top index, backward with and without clamp,
  // zero direction, and history reset.
  task automatic test_trigger_paths();
    wait_idle();
    write_reg(REG_TRIGGER_ENABLE, 32'd1);
    write_reg(REG_FAST_THRESHOLD, 32'd0);
    send_cmd(CMD_EVALUATE, 16'h0000, 48'd0, 24'hFF_FFFF);
    send_cmd(CMD_ADD_SAMPLE, 16'hFFFF, 48'd2000, 24'd0);
    send_cmd(CMD_EVALUATE, 16'h0000, 48'd0, 24'd3);
    send_cmd(CMD_EVALUATE, 16'h0000, 48'd0, 24'hFF_FFFF);
    send_cmd(CMD_ADD_SAMPLE, 16'h0000, 48'd2500, 24'd0);
    send_cmd(CMD_EVALUATE, 16'h0000, 48'd0, 24'd100);
    send_cmd(CMD_RESET_HIST, 16'h7FFF, 48'd9, 24'd9);
    send_cmd(CMD_EVALUATE, 16'h0000, 48'd0, 24'd10);
  endtask

  // Threshold at all ones, just below the floor and at the floor, then triggers off.
  task automatic test_threshold_limits();
    wait_idle();
    write_reg(REG_FAST_THRESHOLD, 32'hFFFF_FFFF);
    send_cmd(CMD_ADD_SAMPLE, 16'h0001, 48'hFFFF_FFFF_FFFE, 24'd0);
    send_cmd(CMD_ADD_SAMPLE, 16'h8000, 48'hFFFF_FFFF_FFFF, 24'd0);
    send_cmd(CMD_EVALUATE, 16'h0000, 48'd0, 24'd0);
    wait_idle();
    write_reg(REG_FAST_THRESHOLD, 32'd255);
    send_cmd(CMD_EVALUATE, 16'h0000, 48'd0, 24'd0);
    wait_idle();
    write_reg(REG_FAST_THRESHOLD, 32'd256);
    send_cmd(CMD_EVALUATE, 16'h0000, 48'd0, 24'h80_0000);
    wait_idle();
    write_reg(REG_TRIGGER_ENABLE, 32'd0);
    send_cmd(CMD_EVALUATE, 16'h0000, 48'd0, 24'h80_0000);
  endtask

  // Hold the receiver off while commands keep coming so the block backs up.
  task automatic test_receiver_hold();
    int i;
    wait_idle();
    write_reg(REG_TRIGGER_ENABLE, 32'd1);
    write_reg(REG_FAST_THRESHOLD, 32'd12800);
    hold_asked <= hold_asked + 1;
    for (i = 0; i < 12; i++) begin
      clock_us = clock_us + 48'd8000;
      if (i % 3 == 2) send_cmd(CMD_EVALUATE, 16'h0000, 48'd0, 24'($urandom));
      else            send_cmd(CMD_ADD_SAMPLE, 16'(i * 7 + 1), clock_us, 24'd0);
    end
  endtask

  // Mostly well-formed scroll streams with increasing timestamps, with evaluates,
  // history resets and a share of fully random commands mixed in.
  task automatic test_random_gestures(int n_items);
    int k, pick;
    logic [15:0] delta;
    logic [47:0] dt;
    for (k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // noise: any command, any field value
        delta = 16'($urandom);
        dt    = {16'($urandom), 32'($urandom)};
        send_cmd(2'($urandom_range(0, 3)), delta, dt, 24'($urandom));
        clock_us = dt;
      end else if (pick < 12) begin
        send_cmd(CMD_RESET_HIST, 16'($urandom), 48'($urandom), 24'($urandom));
      end else if (pick < 40) begin
        send_cmd(CMD_EVALUATE, 16'($urandom), 48'($urandom), 24'($urandom));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 5)       dt = 48'd0;
        else if (pick < 8)  dt = -48'($urandom_range(1, 5000));
        else if (pick < 12) dt = 48'($urandom_range(1, 3));
        else                dt = 48'($urandom_range(500, 60000));
        clock_us = clock_us + dt;
        pick = $urandom_range(0, 99);
        if (pick < 3)       delta = 16'h7FFF;
        else if (pick < 6)  delta = 16'h8000;
        else if (pick < 12) delta = 16'($urandom);
        else begin
          delta = 16'($urandom_range(0, 300));
          if ($urandom_range(0, 2) == 0) delta = -delta;
        end
        send_cmd(CMD_ADD_SAMPLE, delta, clock_us, 24'($urandom));
      end
    end
  endtask

  initial begin
    int p;
    logic [31:0] thr;
    mismatches   = 0;
    cycles       = 0;
    n_sent       = 0;
    n_checked    = 0;
    n_triggers   = 0;
    n_thresholds = 0;
    hold_asked   = 0;
    calm         = 1'b0;
    clock_us     = 48'd0;
    // Predictor starts from the post-reset state.
    thr_reg      = FAST_THRESHOLD_RST;
    trig_en_reg  = 1'b0;
    last_stamp   = '0;
    last_step    = '0;
    sample_count = 0;
    ema_speed    = '0;

    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.command      <= CMD_ADD_SAMPLE;
    in_ch.delta_items  <= '0;
    in_ch.timestamp_us <= '0;
    in_ch.top_index    <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= REG_FAST_THRESHOLD;
    cfg_ch.data        <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_history_edges();
    test_trigger_paths();
    test_threshold_limits();
    test_receiver_hold();

    // Random phases, each under its own register setting; phase 3 runs without idling.
    for (p = 0; p < RAND_PHASES; p++) begin
      wait_idle();
      case (p)
        0:       thr = 32'd256;
        1:       thr = 32'($urandom_range(0, 255));
        2:       thr = 32'($urandom_range(256, 32'h0010_0000));
        3:       thr = 32'($urandom_range(32'h0010_0000, 32'h1000_0000));
        4:       thr = 32'd12800;
        5:       thr = $urandom;
        default: thr = 32'hFFFF_FFFF;
      endcase
      write_reg(REG_FAST_THRESHOLD, thr);
      write_reg(REG_TRIGGER_ENABLE, (p == 4) ? 32'd0 : 32'd1);
      calm <= (p == 3);
      test_random_gestures(PHASE_ITEMS);
    end
    calm <= 1'b0;

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (speed_reports_q.size() != 0)
      report_mismatch("results never delivered", speed_reports_q.size(), 0);

    $display("covered %0d commands, %0d results checked, %0d prefetch triggers,",
             n_sent, n_checked, n_triggers);
    $display("%0d threshold settings, %0d mismatches", n_thresholds, mismatches);
    if (mismatches == 0)
      $display("scroll_velocity_ema_prefetch_core regression: pass");
    else
      $display("scroll_velocity_ema_prefetch_core regression: fail");
    $finish;
  end

endmodule
